// File: rtl/core/roll_variance_swerve_detector_defines.svh
// assertion helpers shared by the detector modules
// both sample on clk and stay quiet while rst_n is low
`ifndef ROLL_VARIANCE_SWERVE_DETECTOR_DEFINES_SVH
`define ROLL_VARIANCE_SWERVE_DETECTOR_DEFINES_SVH

// same-cycle implication
`define RVSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rvsd_pkg.sv
package rvsd_pkg;

  localparam int WINDOW = 50;
  localparam int PTR_W  = $clog2(WINDOW);

  localparam int ROLL_W     = 15;
  localparam int SPEED_W    = 12;
  localparam int LIMIT_W    = 14;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_ADDR_W = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  localparam longint ROLL_PEAK = 11520;
  localparam logic signed [ROLL_W-1:0] ROLL_MAX = 15'sd11520;
  localparam logic signed [ROLL_W-1:0] ROLL_MIN = -15'sd11520;

  // widths of the running sums and the spread test
  localparam int SUM_W  = $clog2(longint'(WINDOW) * ROLL_PEAK + 1) + 1;
  localparam int SQ_W   = $clog2(longint'(WINDOW) * ROLL_PEAK * ROLL_PEAK + 1);
  localparam int DIF_W  = ROLL_W + 1;
  localparam int DSQ_W  = 2 * DIF_W;
  localparam int NSQ_W  = SQ_W + $clog2(WINDOW + 1);
  localparam int SQR_W  = 2 * SUM_W;
  localparam int LIM2_W = 2 * LIMIT_W;
  localparam int WSQ_W  = $clog2(WINDOW * WINDOW + 1);
  localparam int BND_W  = LIM2_W + WSQ_W;
  localparam int MAX_AB = (NSQ_W > SQR_W) ? NSQ_W : SQR_W;
  localparam int CMP_W  = ((MAX_AB > BND_W) ? MAX_AB : BND_W) + 1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [SPEED_W-1:0] SPEED_GATE_RST = 12'd100;
  localparam logic [LIMIT_W-1:0] DEV_LIMIT_RST  = 14'd960;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_GATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEV_LIMIT  = 2'd1;

  typedef struct packed {
    logic                    moving;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
  } rvsd_item_t;

  typedef struct packed {
    logic       empty;
    rvsd_item_t head;
  } rvsd_qstat_t;

endpackage

// File: rtl/core/roll_variance_swerve_detector.sv
// path: front regs s1 and s2, then the queue, then back regs b1, b2 and the output register
// throughput: one transaction per cycle unless stalled; one ring read and write per sample
// the front holds a credit of 4 transactions, so a stalled output stops input once 4 sit
// between the input and the back pipe
// reset: rst_n sync active low; clears ring valids, sums, queue and pipe valids at once
// reset: speed gate returns to 100 and deviation limit to 960; no clearing pass is needed
module roll_variance_swerve_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rvsd_pkg::IN_TDATA_W-1:0]      in_tdata,   // roll_angle[14:0], speed[26:15]
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rvsd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // swerving[0]
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [rvsd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rvsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rvsd_pkg::*;

  logic [SPEED_W-1:0]  speed_gate_r;
  logic [LIMIT_W-1:0]  dev_limit_r;

  logic                push, pop;
  rvsd_item_t          item;
  rvsd_qstat_t         qstat;
  logic                out_flag;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gate_r <= SPEED_GATE_RST;
      dev_limit_r  <= DEV_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SPEED_GATE: speed_gate_r <= cfg_wdata[SPEED_W-1:0];
        CFG_DEV_LIMIT:  dev_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: saturation, ring update and running sums
  rvsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .roll       ($signed(in_tdata[ROLL_W-1:0])),
    .speed      (in_tdata[ROLL_W+SPEED_W-1:ROLL_W]),
    .speed_gate (speed_gate_r),
    .pop        (pop),
    .push       (push),
    .item       (item)
  );

  // short queue so front and back stall independently
  rvsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (item),
    .pop     (pop),
    .qstat   (qstat)
  );

  // back: spread against bound, output register
  rvsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop       (pop),
    .dev_limit (dev_limit_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_flag  (out_flag)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_flag};

endmodule

// File: rtl/core/rvsd_front.sv
`include "roll_variance_swerve_detector_defines.svh"

module rvsd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rvsd_pkg::ROLL_W-1:0]  roll,
  input  logic [rvsd_pkg::SPEED_W-1:0]        speed,
  input  logic [rvsd_pkg::SPEED_W-1:0]        speed_gate,
  input  logic                                pop,
  output logic                                push,
  output rvsd_pkg::rvsd_item_t                item
);
  import rvsd_pkg::*;

  logic                     acc;
  logic signed [ROLL_W-1:0] sample;

  logic [QCNT_W-1:0]        inflight_r, inflight_nxt;
  logic [PTR_W-1:0]         wpos_r, wpos_nxt;

  logic signed [ROLL_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]        ring_vld_r;
  logic signed [ROLL_W-1:0] ring_q;
  logic                     vld_q;

  logic                     s1_vld_r;
  logic signed [ROLL_W-1:0] s1_sample_r;
  logic                     s1_mov_r;
  logic signed [ROLL_W-1:0] old;
  logic signed [DIF_W-1:0]  diff, sumo;

  logic                     s2_vld_r;
  logic                     s2_mov_r;
  logic signed [DIF_W-1:0]  s2_diff_r;
  logic signed [DSQ_W-1:0]  s2_dsq_r;

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sumsq_r, sumsq_nxt;

  // credit: items between acceptance and queue pop
  assign in_ready = (inflight_r < QCNT_W'(QDEPTH));
  assign acc      = in_valid && in_ready;

  always_comb begin
    if (roll > ROLL_MAX) begin
      sample = ROLL_MAX;
    end else if (roll < ROLL_MIN) begin
      sample = ROLL_MIN;
    end else begin
      sample = roll;
    end
  end

  assign inflight_nxt = inflight_r + QCNT_W'(acc) - QCNT_W'(pop);
  assign wpos_nxt     = (wpos_r == PTR_W'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;

  // ring read returns the old entry, write replaces it in the same cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      ring_mem[wpos_r] <= sample;
    end
    ring_q <= ring_mem[wpos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      wpos_r     <= '0;
      ring_vld_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      sum_r      <= '0;
      sumsq_r    <= '0;
    end else begin
      inflight_r <= inflight_nxt;
      s1_vld_r   <= acc;
      s2_vld_r   <= s1_vld_r;
      if (acc) begin
        wpos_r             <= wpos_nxt;
        ring_vld_r[wpos_r] <= 1'b1;
      end
      if (s2_vld_r) begin
        sum_r   <= sum_nxt;
        sumsq_r <= sumsq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q       <= ring_vld_r[wpos_r];
    s1_sample_r <= sample;
    s1_mov_r    <= (speed > speed_gate);
    s2_mov_r    <= s1_mov_r;
    s2_diff_r   <= diff;
    s2_dsq_r    <= DSQ_W'(diff) * DSQ_W'(sumo);
  end

  // new^2 - old^2 as one product
  assign old  = vld_q ? ring_q : '0;
  assign diff = DIF_W'(s1_sample_r) - DIF_W'(old);
  assign sumo = DIF_W'(s1_sample_r) + DIF_W'(old);

  assign sum_nxt   = sum_r + SUM_W'(s2_diff_r);
  assign sumsq_nxt = sumsq_r + SQ_W'(s2_dsq_r);

  assign push       = s2_vld_r;
  assign item.moving = s2_mov_r;
  assign item.sum    = sum_nxt;
  assign item.sumsq  = sumsq_nxt;

  `RVSD_ASSERT_IMP(a_wpos_range, 1'b1, wpos_r < PTR_W'(WINDOW), "write position out of ring")
  `RVSD_ASSERT_IMP(a_credit_max, 1'b1, inflight_r <= QCNT_W'(QDEPTH), "credit count overrun")
  `RVSD_ASSERT_IMP(a_push_credit, s2_vld_r, inflight_r != '0, "push without credit")

endmodule

// File: rtl/core/rvsd_queue.sv
`include "roll_variance_swerve_detector_defines.svh"

module rvsd_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  rvsd_pkg::rvsd_item_t          wr_item,
  input  logic                          pop,
  output rvsd_pkg::rvsd_qstat_t         qstat
);
  import rvsd_pkg::*;

  rvsd_item_t        q_mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign qstat.empty = (count_r == '0);
  assign qstat.head  = q_mem[rptr_r];

  `RVSD_ASSERT_IMP(a_no_overflow, count_r == QCNT_W'(QDEPTH), !push, "push into full queue")
  `RVSD_ASSERT_IMP(a_no_underflow, count_r == '0, !pop, "pop from empty queue")

endmodule

// File: rtl/core/rvsd_back.sv
module rvsd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rvsd_pkg::rvsd_qstat_t         qstat,
  output logic                          pop,
  input  logic [rvsd_pkg::LIMIT_W-1:0]  dev_limit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_flag
);
  import rvsd_pkg::*;

  logic                     adv;
  logic                     b1_vld_r, b1_mov_r;
  logic signed [SQR_W-1:0]  sq_r;
  logic [NSQ_W-1:0]         nsq_r;
  logic [LIM2_W-1:0]        lim2_r;
  logic                     b2_vld_r, b2_mov_r;
  logic signed [CMP_W-1:0]  spread_r;
  logic [BND_W-1:0]         bound_r;
  logic                     out_vld_r, out_flag_r;

  // whole pipe moves when the output register is free or being drained
  assign adv = !out_vld_r || out_ready;
  assign pop = adv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r  <= !qstat.empty;
      b2_vld_r  <= b1_vld_r;
      out_vld_r <= b2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products
      b1_mov_r <= qstat.head.moving;
      sq_r     <= SQR_W'(qstat.head.sum) * SQR_W'(qstat.head.sum);
      nsq_r    <= NSQ_W'(qstat.head.sumsq) * NSQ_W'(WINDOW);
      lim2_r   <= LIM2_W'(dev_limit) * LIM2_W'(dev_limit);
      // spread and bound
      b2_mov_r <= b1_mov_r;
      spread_r <= $signed(CMP_W'(nsq_r)) - CMP_W'(sq_r);
      bound_r  <= BND_W'(lim2_r) * BND_W'(WINDOW * WINDOW);
      // compare
      out_flag_r <= b2_mov_r && (spread_r > $signed(CMP_W'(bound_r)));
    end
  end

  assign out_valid = out_vld_r;
  assign out_flag  = out_flag_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rvsd_pkg::*;

  // register indexes past the end of the register list, writes there are dropped
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int SETTLE_CYCLES = 10;    // margin after the last owed flag is back, so the pipe can empty
  localparam int IDLE_LIMIT    = 1000;  // cycles with no transaction before giving up
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 104;

  // predicts the swerve flag of every accepted sample and holds the flags still owed
  class swerve_flag_tracker;
    int signed          roll_hist[WINDOW];
    int unsigned        slot;
    longint             roll_total;
    longint             roll_sq_total;
    logic [SPEED_W-1:0] gate;
    logic [LIMIT_W-1:0] limit;
    bit                 flags_due[$];
    int                 mismatches;

    function new();
      foreach (roll_hist[i]) roll_hist[i] = 0;
      slot          = 0;
      roll_total    = 0;
      roll_sq_total = 0;
      gate          = SPEED_GATE_RST;
      limit         = DEV_LIMIT_RST;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SPEED_GATE: gate = value[SPEED_W-1:0];
        CFG_DEV_LIMIT:  limit = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return flags_due.size();
    endfunction

    function void take_sample(logic [ROLL_W-1:0] raw, logic [SPEED_W-1:0] spd);
      int signed s;
      int signed old;
      longint    spread;
      longint    bound;
      bit        flag;
      s = int'($signed(raw));
      if (s > int'(ROLL_PEAK)) s = int'(ROLL_PEAK);
      if (s < -int'(ROLL_PEAK)) s = -int'(ROLL_PEAK);
      old = roll_hist[slot];
      roll_hist[slot] = s;
      roll_total    += longint'(s) - longint'(old);
      roll_sq_total += longint'(s) * s - longint'(old) * old;
      slot = (slot + 1 == WINDOW) ? 0 : slot + 1;
      flag = 1'b0;
      if (spd > gate) begin
        spread = longint'(WINDOW) * roll_sq_total - roll_total * roll_total;
        bound  = longint'(WINDOW) * WINDOW * longint'(limit) * longint'(limit);
        flag   = (spread > bound);
      end
      flags_due.push_back(flag);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_flag(logic [OUT_TDATA_W-1:0] data);
      bit want;
      if (flags_due.size() == 0) begin
        report("result transaction with no sample outstanding");
      end else begin
        want = flags_due.pop_front();
        if (data[0] !== want)
          report($sformatf("swerving got %b want %b", data[0], want));
      end
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  swerve_flag_tracker sb;

  // long runs without any idling on either side
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  roll_variance_swerve_detector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // roll_angle[14:0], speed[26:15]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // swerving[0]
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // one input transaction, with a random gap in front unless in a steady stretch
  task send_sample(input int roll, input int spd);
    int gap;
    logic [ROLL_W-1:0]  r;
    logic [SPEED_W-1:0] s;
    r = roll[ROLL_W-1:0];
    s = spd[SPEED_W-1:0];
    if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - ROLL_W - SPEED_W){1'b0}}, s, r};
    do @(posedge clk); while (!in_tready);
    sb.take_sample(r, s);
  endtask

  // stop sending and wait until every owed flag is back, then let the pipe empty
  task settle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // roll around a centre with a spread of amp, now and then raw noise or a bound
  function int pick_roll(int centre, int amp);
    int v;
    case ($urandom_range(0, 15))
      0: v = int'($urandom_range(0, 32767)) - 16384;
      1: begin
        case ($urandom_range(0, 5))
          0: v = 11520;
          1: v = -11520;
          2: v = 11521;
          3: v = -11521;
          4: v = 16383;
          default: v = -16384;
        endcase
      end
      default: begin
        v = centre + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 16383) v = 16383;
        if (v < -16384) v = -16384;
      end
    endcase
    return v;
  endfunction

  // speed clustered around the gate so both sides of it get plenty of traffic
  function int pick_speed();
    case ($urandom_range(0, 7))
      0: return int'(sb.gate);
      1: return int'(sb.gate) + 1;
      2: return int'($urandom_range(0, 4095));
      3: return int'(sb.gate) + int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, 2550));
    endcase
  endfunction

  // result side: random stalls, each flag checked against the oldest owed one
  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_flag(out_tdata);
    end
  end

  // watchdog: any cycle without a transaction on either stream counts
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int centre;
    int amp;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // exactly at the limit: one sample of 350 among 49 zeros gives a deviation of 49
    write_reg(CFG_DEV_LIMIT, 14'd49);
    send_sample(350, 2550);
    send_sample(0, 101);
    send_sample(0, 100);   // speed equal to the gate, forced low
    settle();
    write_reg(CFG_DEV_LIMIT, 14'd48);
    send_sample(0, 4095);
    send_sample(0, 101);
    settle();

    // extremes with everything enabled; spare indexes must leave both registers alone
    write_reg(CFG_SPEED_GATE, 14'd0);
    write_reg(CFG_DEV_LIMIT, 14'd0);
    write_reg(CFG_SPARE_LO, 14'h3fff);
    write_reg(CFG_SPARE_HI, 14'h3fff);
    send_sample(-16384, 1);   // saturates to the lower bound
    send_sample(16383, 0);    // saturates high, stationary
    send_sample(11520, 2550);
    send_sample(-11520, 4095);
    send_sample(11521, 1);
    send_sample(-11521, 2);
    send_sample(0, 1);
    send_sample(-1, 2550);
    send_sample(1, 0);
    settle();

    // upper bits of the data word beyond the gate width are dropped
    write_reg(CFG_SPEED_GATE, 14'h3000 | 14'd2550);
    write_reg(CFG_DEV_LIMIT, 14'd11520);
    send_sample(11520, 2551);
    send_sample(-11520, 4095);
    send_sample(0, 2550);
    settle();

    // random phases, each with its own register setting and roll spread
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SPEED_GATE, 14'd0);
          write_reg(CFG_DEV_LIMIT, 14'd0);
        end
        1: begin
          write_reg(CFG_SPEED_GATE, 14'h3fff);
          write_reg(CFG_DEV_LIMIT, 14'd11520);
        end
        2: begin
          write_reg(CFG_SPEED_GATE, 14'd2550);
          write_reg(CFG_DEV_LIMIT, 14'h3fff);
        end
        3: begin
          write_reg(CFG_SPEED_GATE, CFG_DATA_W'(SPEED_GATE_RST));
          write_reg(CFG_DEV_LIMIT, DEV_LIMIT_RST);
        end
        default: begin
          write_reg(CFG_SPEED_GATE, CFG_DATA_W'($urandom_range(0, 2550)));
          write_reg(CFG_DEV_LIMIT, CFG_DATA_W'($urandom_range(0, 3000)));
        end
      endcase
      // spread roughly around the limit so the flag toggles both ways
      amp = 2 * int'(sb.limit) + int'($urandom_range(0, 256));
      if (amp > 11520) amp = 11520;
      centre = int'($urandom_range(0, 4000)) - 2000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0) amp = int'($urandom_range(0, 4 * int'(sb.limit) + 64));
        if (amp > 11520) amp = 11520;
        send_sample(pick_roll(centre, amp), pick_speed());
        // occasionally hold off until the pipe has drained completely
        if ($urandom_range(0, 49) == 0) settle();
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
